[hw/rtl/bpu_pkg.sv]
// Shared types and constants of the byte plane unshuffle block.
package bpu_pkg;

   localparam int BYTE_W   = 8;
   localparam int VALUE_W  = 64;
   localparam int PART_W   = 56;
   localparam int ROWS_W   = 13;
   localparam int ROW_IDX_W = 12;
   localparam int POS_W    = 16;
   localparam int WIDTH_W  = 4;
   localparam int SYM_W    = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PLANE_W  = 3;
   localparam int MAX_PLANES = 8;

   localparam logic [CSR_IDX_W-1:0] CSR_BYTE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SYMBOL_COUNT = 2'd2;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 4'd8;

   typedef enum logic [1:0] {
      STATUS_OK,
      STATUS_WIDTH,
      STATUS_LENGTH,
      STATUS_CODE
   } status_type;

   // One accepted byte on its way from the address stage to the merge stage.
   typedef struct packed {
      status_type          status;
      logic                last;
      logic                final_plane;
      logic [PLANE_W-1:0]  plane;
      logic [ROWS_W-1:0]   row;
      logic [WIDTH_W-1:0]  width;
      logic [BYTE_W-1:0]   data;
      logic                last_row;
   } stage_type;

endpackage

[hw/rtl/byte_plane_unshuffle.sv]
// Byte plane unshuffle: rebuilds sign-extended row values from a plane-ordered byte stream.
//
// The req channel carries one byte of the blob per beat, with req_last_byte on the final
// byte. Bytes come plane by plane: byte 0 of every row, then byte 1 of every row, and so on.
// The low bytes of each row wait in a row store; the byte of the top plane completes the
// row, which leaves on the rsp channel as a sign-extended value with its row index.
// Width, blob length and, with a nonzero symbol count, the code range are checked; an
// error gives one beat with a nonzero status, and the block is then silent up to and
// including the byte marked last.
// The csr port writes byte_width, row_count and symbol_count; write only between bytes.
// Throughput is one byte per cycle while req_ready is high. A result beat passes the merge
// stage register, which holds the row store read, then the output register. A byte that
// reads the row written by the previous byte takes the written data from a bypass register.
// When rsp_ready is low, one result waits in the output register while the next byte is
// still taken; a second pending result holds the merge stage and drops req_ready.
// Reset loads byte_width 8, row_count 0, symbol_count 0 and starts a fresh blob. The row
// store is not cleared: plane 0 always writes a row before a later plane reads it.
module byte_plane_unshuffle #(
   parameter int MAX_ROWS = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [bpu_pkg::BYTE_W-1:0]           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [bpu_pkg::VALUE_W-1:0]   rsp_value,
   output logic [bpu_pkg::ROW_IDX_W-1:0]        rsp_row_index,
   output logic [1:0]                           rsp_status,
   output logic                                 rsp_last_row,
   input  logic                                 csr_we,
   input  logic [bpu_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bpu_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam logic [31:0] MAX_ROWS_LIMIT = 32'(MAX_ROWS);

   // Configuration.
   logic [bpu_pkg::WIDTH_W-1:0] width_ff;
   logic [bpu_pkg::ROWS_W-1:0]  rows_ff;
   logic [bpu_pkg::SYM_W-1:0]   sym_ff;
   logic [bpu_pkg::POS_W-1:0]   mult_ff [bpu_pkg::MAX_PLANES];

   // Blob state.
   logic [bpu_pkg::POS_W-1:0]   pos_ff;
   logic                        err_ff;

   // Merge stage and output register.
   logic                        s1_valid_ff;
   bpu_pkg::stage_type          s1_ff;
   bpu_pkg::stage_type          s1_in;
   logic                        out_valid_ff;
   logic [bpu_pkg::VALUE_W-1:0] out_value_ff;
   logic [bpu_pkg::ROW_IDX_W-1:0] out_row_ff;
   bpu_pkg::status_type         out_status_ff;
   logic                        out_last_ff;

   // Row store.
   logic [bpu_pkg::PART_W-1:0]  mem [MAX_ROWS];
   logic [bpu_pkg::PART_W-1:0]  rd_ff;
   logic                        byp_ff;
   logic                        byp_in;
   logic [bpu_pkg::PART_W-1:0]  byp_data_ff;

   // Address stage signals.
   logic                        accept;
   logic                        err_eff;
   logic                        width_ok;
   logic [1:0]                  width_shift;
   logic [bpu_pkg::POS_W-1:0]   total;
   logic                        len_err;
   logic [bpu_pkg::PLANE_W-1:0] plane;
   logic [bpu_pkg::POS_W-1:0]   row_wide;
   logic [bpu_pkg::ROWS_W-1:0]  row;
   bpu_pkg::status_type         status;
   logic [AW-1:0]               rd_addr;

   // Merge stage signals.
   logic                        s1_ok;
   logic                        s1_write;
   logic                        s1_has_result;
   logic                        s1_adv;
   logic [bpu_pkg::PART_W-1:0]  base;
   logic [bpu_pkg::VALUE_W-1:0] merged;
   logic [bpu_pkg::VALUE_W-1:0] ext;
   logic                        code_err;
   logic                        code_hold;
   logic [AW-1:0]               wr_addr;
   logic [bpu_pkg::VALUE_W-1:0] res_value;
   logic [bpu_pkg::ROW_IDX_W-1:0] res_row;
   bpu_pkg::status_type         res_status;
   logic                        res_last;

   // ---------------- merge stage ----------------
   always_comb begin
      s1_ok         = (s1_ff.status == bpu_pkg::STATUS_OK);
      s1_write      = s1_valid_ff && s1_ok && !s1_ff.final_plane;
      s1_has_result = !s1_ok || s1_ff.final_plane;
      s1_adv        = !s1_valid_ff || !s1_has_result || !out_valid_ff || rsp_ready;
      wr_addr       = AW'(s1_ff.row);

      if (s1_ff.plane == '0) begin
         base = '0;
      end else if (byp_ff) begin
         base = byp_data_ff;
      end else begin
         base = rd_ff;
      end
      merged = {8'd0, base}
             | ({56'd0, s1_ff.data} << {s1_ff.plane, 3'b000});

      unique case (s1_ff.width)
         4'd1:    ext = {{56{merged[7]}}, merged[7:0]};
         4'd2:    ext = {{48{merged[15]}}, merged[15:0]};
         4'd4:    ext = {{32{merged[31]}}, merged[31:0]};
         default: ext = merged;
      endcase

      code_err  = (sym_ff != '0) && (ext[63] || (ext >= {32'd0, sym_ff}));
      code_hold = s1_valid_ff && s1_ok && s1_ff.final_plane && code_err && !s1_ff.last;

      if (!s1_ok) begin
         res_value  = '0;
         res_row    = '0;
         res_status = s1_ff.status;
         res_last   = s1_ff.last;
      end else if (code_err) begin
         res_value  = ext;
         res_row    = s1_ff.row[bpu_pkg::ROW_IDX_W-1:0];
         res_status = bpu_pkg::STATUS_CODE;
         res_last   = s1_ff.last;
      end else begin
         res_value  = ext;
         res_row    = s1_ff.row[bpu_pkg::ROW_IDX_W-1:0];
         res_status = bpu_pkg::STATUS_OK;
         res_last   = s1_ff.last_row;
      end
   end

   // ---------------- address stage ----------------
   always_comb begin
      req_ready = s1_adv;
      accept    = req_valid && s1_adv;
      // A code error in the merge stage silences the byte right behind it.
      err_eff   = err_ff || code_hold;

      unique case (width_ff)
         4'd1: begin
            width_ok = 1'b1;
            width_shift = 2'd0;
         end
         4'd2: begin
            width_ok = 1'b1;
            width_shift = 2'd1;
         end
         4'd4: begin
            width_ok = 1'b1;
            width_shift = 2'd2;
         end
         4'd8: begin
            width_ok = 1'b1;
            width_shift = 2'd3;
         end
         default: begin
            width_ok = 1'b0;
            width_shift = 2'd0;
         end
      endcase

      total   = {3'd0, rows_ff} << width_shift;
      len_err = (rows_ff == '0) || (32'(rows_ff) > MAX_ROWS_LIMIT) || (pos_ff >= total)
             || (req_last_byte && (({1'b0, pos_ff} + 17'd1) != {1'b0, total}));

      if (!width_ok) begin
         status = bpu_pkg::STATUS_WIDTH;
      end else if (len_err) begin
         status = bpu_pkg::STATUS_LENGTH;
      end else begin
         status = bpu_pkg::STATUS_OK;
      end

      // The plane is the number of nonzero row-count multiples at or below the position.
      plane = '0;
      for (int k = 1; k < bpu_pkg::MAX_PLANES; k++) begin
         if (pos_ff >= mult_ff[k]) begin
            plane = plane + 3'd1;
         end
      end
      row_wide = pos_ff - mult_ff[plane];
      row      = row_wide[bpu_pkg::ROWS_W-1:0];
      rd_addr  = AW'(row);

      s1_in.status      = status;
      s1_in.last        = req_last_byte;
      s1_in.final_plane = ({1'b0, plane} + 4'd1) == width_ff;
      s1_in.plane       = plane;
      s1_in.row         = row;
      s1_in.width       = width_ff;
      s1_in.data        = req_data_byte;
      s1_in.last_row    = ({1'b0, row} + 14'd1) == {1'b0, rows_ff};

      byp_in = accept && s1_write && (rd_addr == wr_addr);
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bpu_pkg::WIDTH_RESET;
         rows_ff      <= '0;
         sym_ff       <= '0;
         for (int k = 0; k < bpu_pkg::MAX_PLANES; k++) begin
            mult_ff[k] <= '0;
         end
         pos_ff       <= '0;
         err_ff       <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               bpu_pkg::CSR_BYTE_WIDTH: begin
                  width_ff <= csr_wdata[bpu_pkg::WIDTH_W-1:0];
               end
               bpu_pkg::CSR_ROW_COUNT: begin
                  rows_ff <= csr_wdata[bpu_pkg::ROWS_W-1:0];
                  for (int k = 0; k < bpu_pkg::MAX_PLANES; k++) begin
                     mult_ff[k] <= 16'(k) * {3'd0, csr_wdata[bpu_pkg::ROWS_W-1:0]};
                  end
               end
               bpu_pkg::CSR_SYMBOL_COUNT: begin
                  sym_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end

         if (s1_adv && code_hold) begin
            err_ff <= 1'b1;
         end
         if (accept) begin
            if (err_eff) begin
               if (req_last_byte) begin
                  err_ff <= 1'b0;
                  pos_ff <= '0;
               end
            end else if (status != bpu_pkg::STATUS_OK) begin
               err_ff <= !req_last_byte;
               if (req_last_byte) begin
                  pos_ff <= '0;
               end
            end else begin
               pos_ff <= req_last_byte ? '0 : pos_ff + 16'd1;
            end
         end

         if (s1_adv) begin
            s1_valid_ff <= accept && !err_eff;
         end

         if (s1_valid_ff && s1_has_result && s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // ---------------- payload registers ----------------
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_ff <= s1_in;
      end
      if (accept) begin
         byp_ff      <= byp_in;
         byp_data_ff <= merged[bpu_pkg::PART_W-1:0];
      end
      if (s1_valid_ff && s1_has_result && s1_adv) begin
         out_value_ff  <= res_value;
         out_row_ff    <= res_row;
         out_status_ff <= res_status;
         out_last_ff   <= res_last;
      end
   end

   // ---------------- row store ----------------
   always_ff @(posedge clock) begin
      if (s1_write) begin
         mem[wr_addr] <= merged[bpu_pkg::PART_W-1:0];
      end
      if (accept) begin
         rd_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_value     = out_value_ff;
   assign rsp_row_index = out_row_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_last_row  = out_last_ff;

endmodule
